// File: rtl/md5sh_pkg.sv
// Package for the MD5 stream hasher: state codes, step constants and round functions.
`timescale 1ns / 1ps

package md5sh_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_STEP,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_PAD80,
      PH_FILL,
      PH_LEN_HI,
      PH_DONE
   } phase_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] PAD_WORD = 32'h0000_0080;
   localparam logic [3:0]  LEN_LO_SLOT = 4'd14;
   localparam logic [3:0]  LAST_SLOT = 4'd15;
   localparam logic [5:0]  LAST_STEP = 6'd63;
   localparam logic [2:0]  FULL_WORD = 3'd4;

   localparam logic [31:0] STEP_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // message word index used by a step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] idx;
      begin
         idx = step[3:0];
         unique case (step[5:4])
            2'd0: msg_index = idx;
            2'd1: msg_index = 4'(idx * 4'd5 + 4'd1);
            2'd2: msg_index = 4'(idx * 4'd3 + 4'd5);
            2'd3: msg_index = 4'(idx * 4'd7);
            default: msg_index = idx;
         endcase
      end
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [4:0] amt;
      begin
         amt = 5'd0;
         unique case ({step[5:4], step[1:0]})
            4'h0: amt = 5'd7;
            4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;
            4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;
            4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;
            4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;
            4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;
            4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;
            4'hd: amt = 5'd10;
            4'he: amt = 5'd15;
            4'hf: amt = 5'd21;
            default: amt = 5'd7;
         endcase
         rot_amount = amt;
      end
   endfunction

   function automatic logic [31:0] round_fn(input logic [1:0] round,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
      begin
         unique case (round)
            2'd0: round_fn = d ^ (b & (c ^ d));
            2'd1: round_fn = c ^ (d & (b ^ c));
            2'd2: round_fn = b ^ c ^ d;
            2'd3: round_fn = c ^ (b | ~d);
            default: round_fn = b ^ c ^ d;
         endcase
      end
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] both;
      begin
         both = {v, v} << s;
         rotl32 = both[63:32];
      end
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] v);
      begin
         bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
      end
   endfunction

endpackage

// File: rtl/md5_stream_hasher.sv
// MD5 stream hasher: block buffer memory, padding sequencer and one-step-per-cycle compression.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   message_word[32], bytes_valid[3], last_item
//   rsp_     out        rsp_valid/rsp_stall   digest_first_half[64], digest_second_half[64]
//
// A word that does not close a block leaves the hasher idle for the next word; the 16th word
// of a block starts a compression (one load, 64 steps, one chain update), one step
// per cycle with the message word read from the buffer memory one step ahead.
// The final word adds the padding words, one or two compressions and one digest load.
// Reset is synchronous and restores the initial chaining values; no clearing pass.
// req_stall is high whenever the hasher is not waiting for a word; a digest that is
// stalled on rsp_ blocks only the next digest, not the next message's words.
`timescale 1ns / 1ps

module md5_stream_hasher
   import md5sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_bytes_valid,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_first_half,
   output logic [63:0] rsp_digest_second_half
);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic        final_ff, final_in;
   logic [63:0] count_ff, count_in;
   logic [3:0]  widx_ff, widx_in;
   logic [5:0]  step_ff, step_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [31:0] ak_ff, ak_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] first_ff, second_ff;

   logic [31:0] buf_mem [16];
   logic [31:0] mem_rdata_ff;
   logic        mem_we;
   logic [31:0] mem_wdata;
   logic [3:0]  rd_addr;

   logic        slot_free;
   logic        rsp_load;
   logic [2:0]  n_sat;
   logic [31:0] tail_word;
   logic [63:0] bit_len;
   logic [31:0] step_sum;
   logic [31:0] new_b;
   logic [5:0]  next_step;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign n_sat     = (req_bytes_valid > FULL_WORD) ? FULL_WORD : req_bytes_valid;
   assign bit_len   = {count_ff[60:0], 3'b000};
   assign next_step = step_ff + 6'd1;

   // mask the final word and place the pad byte above its valid bytes
   always_comb begin
      unique case (n_sat[1:0])
         2'd0: tail_word = PAD_WORD;
         2'd1: tail_word = {16'h0000, PAD_WORD[7:0], req_message_word[7:0]};
         2'd2: tail_word = {8'h00, PAD_WORD[7:0], req_message_word[15:0]};
         2'd3: tail_word = {PAD_WORD[7:0], req_message_word[23:0]};
         default: tail_word = PAD_WORD;
      endcase
   end

   assign step_sum = ak_ff + round_fn(step_ff[5:4], work_ff[1], work_ff[2], work_ff[3])
                     + mem_rdata_ff;
   assign new_b    = work_ff[1] + rotl32(step_sum, rot_amount(step_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (widx_ff == LAST_SLOT) state_in = ST_LOAD;
               else if (req_last_item) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (widx_ff == LAST_SLOT) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_STEP;
         ST_STEP: begin
            if (step_ff == LAST_STEP) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!final_ff) state_in = ST_IDLE;
            else if (phase_ff == PH_DONE) state_in = ST_OUT;
            else state_in = ST_PAD;
         end
         ST_OUT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = '0;
      rd_addr   = msg_index(next_step);
      widx_in   = widx_ff;
      phase_in  = phase_ff;
      final_in  = final_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      ak_in     = ak_ff;
      work_in   = work_ff;
      chain_in  = chain_ff;
      rsp_load  = 1'b0;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_we  = 1'b1;
               widx_in = widx_ff + 4'd1;
               if (!req_last_item) begin
                  mem_wdata = req_message_word;
                  count_in  = count_ff + 64'd4;
               end else begin
                  final_in = 1'b1;
                  count_in = count_ff + {61'd0, n_sat};
                  if (n_sat == FULL_WORD) begin
                     mem_wdata = req_message_word;
                     phase_in  = PH_PAD80;
                  end else begin
                     mem_wdata = tail_word;
                     phase_in  = PH_FILL;
                  end
               end
            end
         end
         ST_PAD: begin
            mem_we  = 1'b1;
            widx_in = widx_ff + 4'd1;
            unique case (phase_ff)
               PH_PAD80: begin
                  mem_wdata = PAD_WORD;
                  phase_in  = PH_FILL;
               end
               PH_FILL: begin
                  if (widx_ff == LEN_LO_SLOT) begin
                     mem_wdata = bit_len[31:0];
                     phase_in  = PH_LEN_HI;
                  end
               end
               PH_LEN_HI: begin
                  mem_wdata = bit_len[63:32];
                  phase_in  = PH_DONE;
               end
               PH_DONE: begin
                  mem_we  = 1'b0;
                  widx_in = widx_ff;
               end
               default: mem_we = 1'b0;
            endcase
         end
         ST_LOAD: begin
            rd_addr = msg_index(6'd0);
            work_in = chain_ff;
            ak_in   = chain_ff[0] + STEP_K[0];
            step_in = 6'd0;
         end
         ST_STEP: begin
            work_in[0] = work_ff[3];
            work_in[1] = new_b;
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            // pre-add the next step's constant to its a word
            ak_in      = work_ff[3] + STEP_K[next_step];
            step_in    = next_step;
         end
         ST_FINAL: begin
            for (int i = 0; i < 4; i++) chain_in[i] = chain_ff[i] + work_ff[i];
            step_in = 6'd0;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               chain_in[0] = INIT_A;
               chain_in[1] = INIT_B;
               chain_in[2] = INIT_C;
               chain_in[3] = INIT_D;
               for (int i = 0; i < 4; i++) work_in[i] = '0;
               count_in    = '0;
               widx_in     = '0;
               final_in    = 1'b0;
               phase_in    = PH_FILL;
            end
         end
         default: ;
      endcase

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FILL;
         final_ff     <= 1'b0;
         count_ff     <= '0;
         widx_ff      <= '0;
         step_ff      <= '0;
         chain_ff[0]  <= INIT_A;
         chain_ff[1]  <= INIT_B;
         chain_ff[2]  <= INIT_C;
         chain_ff[3]  <= INIT_D;
         for (int i = 0; i < 4; i++) work_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         final_ff     <= final_in;
         count_ff     <= count_in;
         widx_ff      <= widx_in;
         step_ff      <= step_in;
         chain_ff     <= chain_in;
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ak_ff <= ak_in;
      if (rsp_load) begin
         first_ff  <= {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
         second_ff <= {bswap32(chain_ff[2]), bswap32(chain_ff[3])};
      end
   end

   // block buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) buf_mem[widx_ff] <= mem_wdata;
      mem_rdata_ff <= buf_mem[rd_addr];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_digest_first_half  = first_ff;
   assign rsp_digest_second_half = second_ff;

   a_no_write_in_steps : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> !mem_we)
      else $error("buffer written during compression");

   a_load_on_full_block : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (widx_ff == 4'd0))
      else $error("compression started on a partial block");

   a_digest_clears_state : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && (count_ff == 64'd0) && !final_ff && (state_ff == ST_IDLE)))
      else $error("digest transfer did not restart the hasher");

endmodule
